FILE: sv/afrf_pkg.sv
// ----------------------------------------------------------------------------
// afrf_pkg: shared types and constants for the audio frame ring FIFO
// Field widths, request and result structs, controller states and the
// command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package afrf_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CNT_W    = 11;
  localparam int CH_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W   = 4;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample_in;
    logic                batch_last;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic                accepted;
    logic [CNT_W-1:0]    frames_readable;
    logic [CNT_W-1:0]    frames_writable;
    logic [CNT_W-1:0]    batch_frames;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;    // take the request, touch the store, load the dividers
    logic div_step;  // one quotient bit in every divider lane
    logic out_load;  // move the finished result into the output register
  } ctrl_cmd_t;

endpackage

FILE: sv/afrf_dpath.sv
// ----------------------------------------------------------------------------
// afrf_dpath: sample store, ring indices and frame dividers
// Holds the configuration, the sample memory, the read and write indices,
// the fill and batch counts, three bit-serial dividers and the result register.
// ----------------------------------------------------------------------------
module afrf_dpath #(
  parameter int DEPTH        = 1024,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  afrf_pkg::ctrl_cmd_t            cmd,
  input  afrf_pkg::in_item_t             in_data,
  input  logic                           cfg_we,
  input  logic [afrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afrf_pkg::CNT_W-1:0]     cfg_data,
  output afrf_pkg::out_item_t            out_data
);
  import afrf_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int CAP_RESET = (DEPTH < 1024) ? DEPTH : 1024;
  localparam int CH_RESET  = (MAX_CHANNELS < 2) ? 1 : 2;
  localparam logic [CNT_W-1:0] BATCH_MAX = {CNT_W{1'b1}};

  logic [CNT_W-1:0]    cap_m1;
  logic [CH_W-1:0]     channels;
  logic [IDX_W-1:0]    read_index;
  logic [IDX_W-1:0]    write_index;
  logic [CNT_W-1:0]    used;
  logic [CNT_W-1:0]    batch_samples;
  logic [SAMPLE_W-1:0] sample_store [DEPTH];
  logic [SAMPLE_W-1:0] rdata;
  logic                read_ok;
  logic                item_ok;
  logic [CH_W-1:0]     rem [3];
  logic [CNT_W-1:0]    quo [3];

  logic             is_full;
  logic             is_empty;
  logic             wr_ok;
  logic             rd_ok;
  logic [CNT_W-1:0] used_next;
  logic [CNT_W-1:0] batch_inc;
  logic [CNT_W-1:0] dividend [3];
  logic [IDX_W-1:0] read_index_next;
  logic [IDX_W-1:0] write_index_next;
  logic [CH_W-1:0]  rem_next [3];
  logic [CNT_W-1:0] quo_next [3];
  logic [CNT_W-1:0] cap_wr;
  logic [CH_W-1:0]  ch_wr;

  // Request bookkeeping; the fill count stands in for the index difference.
  always_comb begin
    is_full  = (used == cap_m1);
    is_empty = (used == '0);
    wr_ok    = (in_data.mode == MODE_WRITE) && !is_full;
    rd_ok    = (in_data.mode == MODE_READ) && !is_empty;
    used_next = used;
    if (wr_ok) begin
      used_next = used + 1'b1;
    end else if (rd_ok) begin
      used_next = used - 1'b1;
    end
    batch_inc = batch_samples;
    if ((wr_ok || rd_ok) && (batch_samples != BATCH_MAX)) begin
      batch_inc = batch_samples + 1'b1;
    end
    dividend[0] = used_next;
    dividend[1] = cap_m1 - used_next;
    dividend[2] = in_data.batch_last ? batch_inc : '0;
    write_index_next = (CMP_W'(write_index) == CMP_W'(cap_m1)) ? '0 : write_index + 1'b1;
    read_index_next  = (CMP_W'(read_index) == CMP_W'(cap_m1)) ? '0 : read_index + 1'b1;
  end

  // Configuration values are clamped into range as they are written.
  always_comb begin
    cap_wr = cfg_data;
    if (cfg_data < CNT_W'(2)) begin
      cap_wr = CNT_W'(2);
    end else if (int'(cfg_data) > DEPTH) begin
      cap_wr = CNT_W'(DEPTH);
    end
    ch_wr = cfg_data[CH_W-1:0];
    if (ch_wr == '0) begin
      ch_wr = CH_W'(1);
    end else if (int'(ch_wr) > MAX_CHANNELS) begin
      ch_wr = CH_W'(MAX_CHANNELS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_m1        <= CNT_W'(CAP_RESET - 1);
      channels      <= CH_W'(CH_RESET);
      read_index    <= '0;
      write_index   <= '0;
      used          <= '0;
      batch_samples <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_CAPACITY) begin
        cap_m1      <= cap_wr - 1'b1;
        read_index  <= '0;
        write_index <= '0;
        used        <= '0;
      end else if (cfg_index == REG_CHANNELS) begin
        channels <= ch_wr;
      end
    end else if (cmd.accept) begin
      used          <= used_next;
      batch_samples <= in_data.batch_last ? '0 : batch_inc;
      if (wr_ok) begin
        write_index <= write_index_next;
      end
      if (rd_ok) begin
        read_index <= read_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_ok) begin
      sample_store[write_index] <= in_data.sample_in;
    end
    if (cmd.accept) begin
      rdata <= sample_store[read_index];
    end
  end

  // Restoring division, one quotient bit per lane each step. The quotient
  // register starts out holding the dividend and shifts it into the remainder.
  always_comb begin
    logic [CH_W:0] trial;
    for (int i = 0; i < 3; i++) begin
      trial = {rem[i], quo[i][CNT_W-1]};
      if (trial >= {1'b0, channels}) begin
        rem_next[i] = CH_W'(trial - {1'b0, channels});
        quo_next[i] = {quo[i][CNT_W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[CH_W-1:0];
        quo_next[i] = {quo[i][CNT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.accept) begin
        rem[i] <= '0;
        quo[i] <= dividend[i];
      end else if (cmd.div_step) begin
        rem[i] <= rem_next[i];
        quo[i] <= quo_next[i];
      end
    end
    if (cmd.accept) begin
      read_ok <= rd_ok;
      item_ok <= wr_ok || rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.sample_out      <= read_ok ? rdata : '0;
      out_data.accepted        <= item_ok;
      out_data.frames_readable <= quo[0];
      out_data.frames_writable <= quo[1];
      out_data.batch_frames    <= quo[2];
    end
  end

endmodule

FILE: sv/afrf_ctrl.sv
// ----------------------------------------------------------------------------
// afrf_ctrl: sequencing for the audio frame ring FIFO
// Takes one request at a time, steps the dividers through every quotient bit
// and hands the result to the output register once that register is free.
// ----------------------------------------------------------------------------
module afrf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                cfg_ready,
  output afrf_pkg::ctrl_cmd_t cmd
);
  import afrf_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic              out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step == LAST_STEP) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall   = 1'b0;
        // A pending request goes first so the two never land on the same edge.
        cfg_ready  = !in_valid;
        cmd.accept = in_valid;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_step) begin
        step <= (step == LAST_STEP) ? '0 : step + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/audio_frame_ring_fifo.sv
// ----------------------------------------------------------------------------
// audio_frame_ring_fifo: circular sample FIFO with whole-frame accounting
// Each request writes or reads one 32-bit sample; every result reports the
// whole frames readable and writable and, on a batch end, the frames moved.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data, one result per request, in order. Register
// 0 sets the capacity in samples (writing it empties the buffer), register 1
// the channels per frame; writes are taken on cfg_valid && cfg_ready, which
// is high only while no request is in work or offered on the input.
// From acceptance until a request lands in the output register, the
// accepting edge does the store access and loads the dividers, then a
// bit-serial divide by the channel count runs (one quotient bit per cycle,
// three lanes in parallel) and the result is loaded once the register is free.
// The next request can be taken the cycle after that load; no new request
// is taken while one is still in work.
// A stalled result waits in the output register while the next request is
// worked on; that request then holds in the done state until the register
// frees up. Synchronous reset empties the buffer, clears the batch count,
// restores capacity min(DEPTH, 1024) and two channels (one if MAX_CHANNELS < 2); the sample memory is not cleared.
// ----------------------------------------------------------------------------
module audio_frame_ring_fifo #(
  parameter int DEPTH        = 1024,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  afrf_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output afrf_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afrf_pkg::CNT_W-1:0]     cfg_data
);
  import afrf_pkg::*;

  ctrl_cmd_t cmd;
  logic      cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  afrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  afrf_dpath #(
    .DEPTH        (DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  // A refused request never carries sample data.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.accepted |-> out_data.sample_out == '0)
    else $error("refused request returned nonzero sample");

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  // A new result only appears after a request was being worked on.
  a_result_follows_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in work");

  // Configuration is never taken while a request is in work.
  a_cfg_when_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !in_stall)
    else $error("configuration taken while busy");

endmodule
